### rtl/core/ils_pkg.sv
// ils_pkg: shared constants, command and status codes, and the result word struct
// for the indexed list store; no dependencies
`default_nettype none

package ils_pkg;

   // field widths fixed by the item format
   localparam int CMD_W       = 4;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 8;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;

   // default list capacity
   localparam int CAPACITY_DEFAULT = 16;

   // command codes
   localparam logic [CMD_W-1:0] CMD_APPEND    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PREPEND   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_READ      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_WRITE     = 4'd3;
   localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DEL_FIRST = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DEL_LAST  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DEL_INDEX = 4'd8;
   localparam logic [CMD_W-1:0] CMD_DEL_RANGE = 4'd9;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // finished result word handed from the sequencer to the output register
   typedef struct packed {
      logic                       valid;
      logic signed [VALUE_W-1:0]  read_value;
      logic [COUNT_OUT_W-1:0]     entry_count;
      logic [STATUS_W-1:0]        status;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/core/ils_if.sv
// ils_if: valid/ready channel interfaces for command words and result words
// depends on ils_pkg for field widths
`default_nettype none

interface ils_req_if;
   logic                               valid;
   logic                               ready;
   logic [ils_pkg::CMD_W-1:0]          cmd;
   logic signed [ils_pkg::VALUE_W-1:0] value;
   logic [ils_pkg::POS_W-1:0]          position;
   logic [ils_pkg::POS_W-1:0]          last_position;

   modport source (output valid, cmd, value, position, last_position, input ready);
   modport sink   (input valid, cmd, value, position, last_position, output ready);
endinterface

interface ils_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [ils_pkg::VALUE_W-1:0]     read_value;
   logic [ils_pkg::COUNT_OUT_W-1:0]        entry_count;
   logic [ils_pkg::STATUS_W-1:0]           status;

   modport source (output valid, read_value, entry_count, status, input ready);
   modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

`default_nettype wire

### rtl/core/indexed_list_store_top.sv
// indexed_list_store_top: top level of the indexed list store with the result register
// depends on ils_pkg, ils_if, ils_ram, ils_step_unit and ils_ctrl
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit entries kept packed at positions
// 0..count-1, with append, prepend, insert, read, write, clear and four kinds of
// delete. Every command word yields one result word with the read data (zero
// unless a read succeeds), the entry count after the command (low 5 bits) and a
// status: ok, bad index or range, or list full. A rejected command leaves the list
// unchanged. Commands are taken one at a time; a command that shifts entries
// takes longer the more entries have to shift, since each such entry needs a
// read and a write through the single ram port pair and the shared index unit.
// Results go to an output register, so the next command is taken while a result
// waits. Reset empties the list at once; entry contents are undefined until written.
module indexed_list_store_top #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   ils_req_if.sink  req_ch,
   ils_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic                            idle;
   logic                            start;
   logic                            out_free;
   ils_pkg::rsp_word_type           result;
   logic                            ram_we;
   logic [IW-1:0]                   ram_waddr;
   logic [IW-1:0]                   ram_raddr;
   logic [ils_pkg::VALUE_W-1:0]     ram_wdata;
   logic [ils_pkg::VALUE_W-1:0]     ram_rdata;
   logic                            unit_remove;
   logic [CW-1:0]                   unit_idx, unit_lim, unit_step;
   logic [CW-1:0]                   unit_src, unit_nxt;
   logic                            unit_more;

   logic                               rsp_valid_ff;
   logic signed [ils_pkg::VALUE_W-1:0] rsp_read_value_ff;
   logic [ils_pkg::COUNT_OUT_W-1:0]    rsp_entry_count_ff;
   logic [ils_pkg::STATUS_W-1:0]       rsp_status_ff;

   // command handshake
   assign req_ch.ready = idle;
   assign start        = req_ch.valid && idle;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   ils_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .cmd           (req_ch.cmd),
      .value         (req_ch.value),
      .position      (req_ch.position),
      .last_position (req_ch.last_position),
      .idle          (idle),
      .out_free      (out_free),
      .result        (result),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata),
      .unit_remove   (unit_remove),
      .unit_idx      (unit_idx),
      .unit_lim      (unit_lim),
      .unit_step     (unit_step),
      .unit_src      (unit_src),
      .unit_nxt      (unit_nxt),
      .unit_more     (unit_more)
   );

   ils_step_unit #(.CAPACITY(CAPACITY)) u_step (
      .remove (unit_remove),
      .idx    (unit_idx),
      .lim    (unit_lim),
      .step   (unit_step),
      .src    (unit_src),
      .nxt    (unit_nxt),
      .more   (unit_more)
   );

   ils_ram #(.CAPACITY(CAPACITY)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_read_value_ff  <= result.read_value;
         rsp_entry_count_ff <= result.entry_count;
         rsp_status_ff      <= result.status;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_value  = rsp_read_value_ff;
   assign rsp_ch.entry_count = rsp_entry_count_ff;
   assign rsp_ch.status      = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/core/ils_ram.sv
// ils_ram: entry storage, one write port and one registered read port
// depends on ils_pkg for the value width
`default_nettype none

module ils_ram #(
   parameter int  CAPACITY = ils_pkg::CAPACITY_DEFAULT,
   localparam int IW       = $clog2(CAPACITY)
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [IW-1:0]                  waddr,
   input  wire logic [ils_pkg::VALUE_W-1:0]    wdata,
   input  wire logic [IW-1:0]                  raddr,
   output logic      [ils_pkg::VALUE_W-1:0]    rdata
);

   logic [ils_pkg::VALUE_W-1:0] store_ff [CAPACITY];
   logic [ils_pkg::VALUE_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### rtl/core/ils_step_unit.sv
// ils_step_unit: shared index unit for entry moves; gives source index, next index
// and whether another move is due; depends on ils_pkg only for the default capacity
`default_nettype none

module ils_step_unit #(
   parameter int  CAPACITY = ils_pkg::CAPACITY_DEFAULT,
   localparam int CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic          remove,   // 1: close a gap upward, 0: open a gap downward
   input  wire logic [CW-1:0] idx,
   input  wire logic [CW-1:0] lim,
   input  wire logic [CW-1:0] step,
   output logic      [CW-1:0] src,
   output logic      [CW-1:0] nxt,
   output logic               more
);

   logic [CW:0] sum;

   // index sums and compares, steered by direction
   always_comb begin
      sum = {1'b0, idx} + {1'b0, step};
      if (remove) begin
         src  = sum[CW-1:0];
         nxt  = idx + CW'(1);
         more = sum < {1'b0, lim};
      end else begin
         src  = idx - CW'(1);
         nxt  = idx - CW'(1);
         more = idx > lim;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ils_ctrl.sv
// ils_ctrl: command decode and sequencer that moves entries one at a time
// through the step unit and the entry ram; depends on ils_pkg
`default_nettype none

module ils_ctrl #(
   parameter int  CAPACITY = ils_pkg::CAPACITY_DEFAULT,
   localparam int CW       = $clog2(CAPACITY + 1),
   localparam int IW       = $clog2(CAPACITY)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // command word
   input  wire logic                           start,
   input  wire logic [ils_pkg::CMD_W-1:0]      cmd,
   input  wire logic [ils_pkg::VALUE_W-1:0]    value,
   input  wire logic [ils_pkg::POS_W-1:0]      position,
   input  wire logic [ils_pkg::POS_W-1:0]      last_position,
   output logic                                idle,
   // result word
   input  wire logic                           out_free,
   output ils_pkg::rsp_word_type               result,
   // entry ram
   output logic                                ram_we,
   output logic      [IW-1:0]                  ram_waddr,
   output logic      [ils_pkg::VALUE_W-1:0]    ram_wdata,
   output logic      [IW-1:0]                  ram_raddr,
   input  wire logic [ils_pkg::VALUE_W-1:0]    ram_rdata,
   // step unit
   output logic                                unit_remove,
   output logic      [CW-1:0]                  unit_idx,
   output logic      [CW-1:0]                  unit_lim,
   output logic      [CW-1:0]                  unit_step,
   input  wire logic [CW-1:0]                  unit_src,
   input  wire logic [CW-1:0]                  unit_nxt,
   input  wire logic                           unit_more
);

   localparam int XW = CW + ils_pkg::POS_W;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_RD_ADDR = 7'b0000010,
      S_RD_DATA = 7'b0000100,
      S_MOVE_RD = 7'b0001000,
      S_MOVE_WR = 7'b0010000,
      S_PUT     = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [CW-1:0]                     lim_ff, lim_in;
   logic [CW-1:0]                     step_ff, step_in;
   logic [CW-1:0]                     put_ff, put_in;
   logic                              remove_ff, remove_in;
   logic [ils_pkg::VALUE_W-1:0]       value_ff, value_in;
   logic [ils_pkg::VALUE_W-1:0]       rd_ff, rd_in;
   logic [ils_pkg::STATUS_W-1:0]      st_ff, st_in;

   // decode results for the word being accepted
   state_type                         go_state;
   logic [CW-1:0]                     d_count, d_idx, d_lim, d_step, d_put;
   logic                              d_remove;
   logic [ils_pkg::STATUS_W-1:0]      d_st;
   logic [XW-1:0]                     cnt_x, pos_x, last_x, span_x;
   logic [CW-1:0]                     pos_c;
   logic                              full;

   // range checks and work plan for one command word
   always_comb begin
      cnt_x    = XW'(count_ff);
      pos_x    = XW'(position);
      last_x   = XW'(last_position);
      span_x   = last_x - pos_x + XW'(1);
      pos_c    = pos_x[CW-1:0];
      full     = count_ff == CW'(CAPACITY);
      go_state = S_DONE;
      d_count  = count_ff;
      d_idx    = count_ff;
      d_lim    = count_ff;
      d_step   = CW'(1);
      d_put    = count_ff;
      d_remove = 1'b0;
      d_st     = ils_pkg::ST_OK;
      case (cmd)
         ils_pkg::CMD_APPEND: begin
            if (full) begin
               d_st = ils_pkg::ST_FULL;
            end else begin
               go_state = S_MOVE_RD;
               d_count  = count_ff + CW'(1);
            end
         end
         ils_pkg::CMD_PREPEND: begin
            if (full) begin
               d_st = ils_pkg::ST_FULL;
            end else begin
               go_state = S_MOVE_RD;
               d_count  = count_ff + CW'(1);
               d_lim    = '0;
               d_put    = '0;
            end
         end
         ils_pkg::CMD_READ: begin
            if (pos_x < cnt_x) begin
               go_state = S_RD_ADDR;
               d_put    = pos_c;
            end else begin
               d_st = ils_pkg::ST_BAD;
            end
         end
         ils_pkg::CMD_WRITE: begin
            if (pos_x < cnt_x) begin
               go_state = S_PUT;
               d_put    = pos_c;
            end else begin
               d_st = ils_pkg::ST_BAD;
            end
         end
         ils_pkg::CMD_INSERT: begin
            if (pos_x > cnt_x) begin
               d_st = ils_pkg::ST_BAD;
            end else if (full) begin
               d_st = ils_pkg::ST_FULL;
            end else begin
               go_state = S_MOVE_RD;
               d_count  = count_ff + CW'(1);
               d_lim    = pos_c;
               d_put    = pos_c;
            end
         end
         ils_pkg::CMD_CLEAR: begin
            d_count = '0;
         end
         ils_pkg::CMD_DEL_FIRST: begin
            // empty list: quietly nothing to do
            if (count_ff != '0) begin
               go_state = S_MOVE_RD;
               d_remove = 1'b1;
               d_idx    = '0;
               d_count  = count_ff - CW'(1);
            end
         end
         ils_pkg::CMD_DEL_LAST: begin
            if (count_ff != '0) begin
               go_state = S_MOVE_RD;
               d_remove = 1'b1;
               d_idx    = count_ff - CW'(1);
               d_count  = count_ff - CW'(1);
            end else begin
               d_st = ils_pkg::ST_BAD;
            end
         end
         ils_pkg::CMD_DEL_INDEX: begin
            if (pos_x < cnt_x) begin
               go_state = S_MOVE_RD;
               d_remove = 1'b1;
               d_idx    = pos_c;
               d_count  = count_ff - CW'(1);
            end else begin
               d_st = ils_pkg::ST_BAD;
            end
         end
         ils_pkg::CMD_DEL_RANGE: begin
            if (pos_x <= last_x && last_x < cnt_x) begin
               go_state = S_MOVE_RD;
               d_remove = 1'b1;
               d_idx    = pos_c;
               d_step   = span_x[CW-1:0];
               d_count  = count_ff - span_x[CW-1:0];
            end else begin
               d_st = ils_pkg::ST_BAD;
            end
         end
         default: begin
            d_st = ils_pkg::ST_BAD;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      lim_in    = lim_ff;
      step_in   = step_ff;
      put_in    = put_ff;
      remove_in = remove_ff;
      value_in  = value_ff;
      rd_in     = rd_ff;
      st_in     = st_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in  = go_state;
               count_in  = d_count;
               idx_in    = d_idx;
               lim_in    = d_lim;
               step_in   = d_step;
               put_in    = d_put;
               remove_in = d_remove;
               value_in  = value;
               rd_in     = '0;
               st_in     = d_st;
            end
         end
         S_RD_ADDR: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            rd_in    = ram_rdata;
            state_in = S_DONE;
         end
         S_MOVE_RD: begin
            if (unit_more) begin
               state_in = S_MOVE_WR;
            end else if (remove_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PUT;
            end
         end
         S_MOVE_WR: begin
            idx_in   = unit_nxt;
            state_in = S_MOVE_RD;
         end
         S_PUT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      lim_ff    <= lim_in;
      step_ff   <= step_in;
      put_ff    <= put_in;
      remove_ff <= remove_in;
      value_ff  <= value_in;
      rd_ff     <= rd_in;
      st_ff     <= st_in;
   end

   // step unit operands
   assign unit_remove = remove_ff;
   assign unit_idx    = idx_ff;
   assign unit_lim    = lim_ff;
   assign unit_step   = step_ff;

   // ram access: a move reads the source then writes it to the slot at the current index
   always_comb begin
      ram_we    = (state_ff == S_MOVE_WR) || (state_ff == S_PUT);
      ram_waddr = (state_ff == S_MOVE_WR) ? idx_ff[IW-1:0] : put_ff[IW-1:0];
      ram_wdata = (state_ff == S_MOVE_WR) ? ram_rdata : value_ff;
      ram_raddr = (state_ff == S_MOVE_RD) ? unit_src[IW-1:0] : put_ff[IW-1:0];
   end

   // result word
   always_comb begin
      result.valid       = (state_ff == S_DONE) && out_free;
      result.read_value  = rd_ff;
      result.entry_count = ils_pkg::COUNT_OUT_W'(count_ff);
      result.status      = st_ff;
   end

   assign idle = state_ff == S_IDLE;

endmodule

`default_nettype wire
